/* rtl/core/salf_pkg.sv */
// Shared types and constants of the set-associative cache with LRU/FIFO replacement.
// No dependencies; imported by every module of the block but salf_ram.
package salf_pkg;

  localparam int CACHE_SETS = 256;
  localparam int SET_W      = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 4;
  localparam int WAY_FLD_W  = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_POLICY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WAYS   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SETB   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFB   = 2'd3;

  localparam logic POLICY_FIFO = 1'b0;
  localparam logic POLICY_LRU  = 1'b1;

  typedef struct packed {
    logic       policy;
    logic [3:0] ways;
    logic [3:0] set_bits;
    logic [3:0] offset_bits;
  } cfg_t;

  typedef struct packed {
    logic                 hit;
    logic [WAY_FLD_W-1:0] way;
  } lk_res_t;

endpackage

/* rtl/core/set_assoc_cache_lru_fifo.sv */
// Top level of the set-associative cache with LRU/FIFO replacement, write-through.
// Depends on salf_pkg, salf_split, salf_ram and salf_lookup.
//
//   channel | ports                                  | direction
//   in      | in_valid/in_ready, in_address, in_is_write | access beat in
//   out     | out_valid/out_ready, out_hit .. out_write_total | result beat out
//   cfg     | cfg_we, cfg_index, cfg_data            | register write
//
// An access reads the set row from the RAM at the accept edge; in ST_LOOK it then
// compares, updates ages and writes the row back once the result register is free.
// The RAM read/modify/write of one set row sets the rate: one access at a time.
// A result waiting on out_ready holds the lookup; a new beat is taken meanwhile.
// Reset clears the per-set row-seen flags; no clearing pass is needed.
module set_assoc_cache_lru_fifo #(
  parameter int ADDR_BITS = 48,
  parameter int MAX_WAYS  = 8
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [salf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [salf_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [ADDR_BITS-1:0]           in_address,
  input  logic                           in_is_write,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           out_hit,
  output logic [2:0]                     out_way_used,
  output logic                           out_mem_read,
  output logic                           out_mem_write,
  output logic [31:0]                    out_hit_total,
  output logic [31:0]                    out_miss_total,
  output logic [31:0]                    out_write_total
);
  import salf_pkg::*;

  localparam int AGE_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int ROW_W = MAX_WAYS * (1 + ADDR_BITS + AGE_W);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_LOOK = 1'b1;

  cfg_t                 cfg_r;
  logic                 state_r, state_nxt;
  logic [SET_W-1:0]     set_in;
  logic [ADDR_BITS-1:0] tag_in;
  logic [SET_W-1:0]     set_r;
  logic [ADDR_BITS-1:0] tag_r;
  logic                 wr_r;
  logic                 row_ok_r;
  logic [CACHE_SETS-1:0] row_seen_r;
  logic [ROW_W-1:0]     row_rd;
  logic [ROW_W-1:0]     row_eff;
  logic [ROW_W-1:0]     row_nxt;
  lk_res_t              res;
  logic                 accept;
  logic                 done;
  logic [31:0]          hits_r, misses_r, writes_r;
  logic                 out_valid_r;
  logic                 hit_r;
  logic [2:0]           way_r;
  logic                 mem_write_r;

  salf_split #(.ADDR_BITS(ADDR_BITS)) u_split (
    .address_i (in_address),
    .cfg_i     (cfg_r),
    .set_o     (set_in),
    .tag_o     (tag_in)
  );

  salf_ram #(.DEPTH(CACHE_SETS), .WIDTH(ROW_W)) u_ram (
    .clk   (clk),
    .we    (done),
    .waddr (set_r),
    .wdata (row_nxt),
    .re    (accept),
    .raddr (set_in),
    .rdata (row_rd)
  );

  assign row_eff = {row_rd[ROW_W-1:MAX_WAYS], row_rd[MAX_WAYS-1:0] & {MAX_WAYS{row_ok_r}}};

  salf_lookup #(.ADDR_BITS(ADDR_BITS), .MAX_WAYS(MAX_WAYS), .ROW_W(ROW_W)) u_lookup (
    .cfg_i (cfg_r),
    .row_i (row_eff),
    .tag_i (tag_r),
    .res_o (res),
    .row_o (row_nxt)
  );

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign done     = (state_r == ST_LOOK) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_LOOK;
        end
      end
      ST_LOOK: begin
        if (done) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.policy      <= POLICY_LRU;
      cfg_r.ways        <= 4'd1;
      cfg_r.set_bits    <= 4'd0;
      cfg_r.offset_bits <= 4'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_POLICY: cfg_r.policy      <= cfg_data[0];
        CFG_WAYS:   cfg_r.ways        <= cfg_data;
        CFG_SETB:   cfg_r.set_bits    <= cfg_data;
        CFG_OFFB:   cfg_r.offset_bits <= cfg_data;
        default:    ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      row_seen_r  <= '0;
      hits_r      <= '0;
      misses_r    <= '0;
      writes_r    <= '0;
    end else begin
      state_r <= state_nxt;
      if (done) begin
        out_valid_r       <= 1'b1;
        row_seen_r[set_r] <= 1'b1;
        if (res.hit) begin
          hits_r <= (hits_r == 32'hFFFF_FFFF) ? hits_r : hits_r + 32'd1;
        end else begin
          misses_r <= (misses_r == 32'hFFFF_FFFF) ? misses_r : misses_r + 32'd1;
        end
        if (wr_r) begin
          writes_r <= (writes_r == 32'hFFFF_FFFF) ? writes_r : writes_r + 32'd1;
        end
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      set_r    <= set_in;
      tag_r    <= tag_in;
      wr_r     <= in_is_write;
      row_ok_r <= row_seen_r[set_in];
    end
    if (done) begin
      hit_r       <= res.hit;
      way_r       <= res.way[2:0];
      mem_write_r <= wr_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_hit         = hit_r;
  assign out_way_used    = way_r;
  assign out_mem_read    = !hit_r;
  assign out_mem_write   = mem_write_r;
  assign out_hit_total   = hits_r;
  assign out_miss_total  = misses_r;
  assign out_write_total = writes_r;

`ifndef SYNTHESIS
  a_accept_to_look: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == ST_LOOK))
    else $error("accepted beat did not start a lookup");

  a_done_gives_beat: assert property (@(posedge clk) disable iff (!rst_n)
    done |=> out_valid_r)
    else $error("finished lookup produced no result beat");

  a_totals_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> ($stable(hits_r) && $stable(misses_r)
                                     && $stable(writes_r)))
    else $error("totals changed while a result beat waits");

  a_one_fill: assert property (@(posedge clk) disable iff (!rst_n)
    done |-> $onehot0(row_nxt[MAX_WAYS-1:0] & ~row_eff[MAX_WAYS-1:0]))
    else $error("more than one way filled by one access");
`endif

endmodule

/* rtl/core/salf_split.sv */
// Address split into set index and tag from the configured geometry.
// Depends on salf_pkg.
module salf_split #(
  parameter int ADDR_BITS = 48
) (
  input  logic [ADDR_BITS-1:0]      address_i,
  input  salf_pkg::cfg_t            cfg_i,
  output logic [salf_pkg::SET_W-1:0] set_o,
  output logic [ADDR_BITS-1:0]      tag_o
);
  import salf_pkg::*;

  logic [ADDR_BITS-1:0] shifted;
  logic [4:0]           tag_sh;

  assign shifted = address_i >> cfg_i.offset_bits;
  assign tag_sh  = {1'b0, cfg_i.offset_bits} + {1'b0, cfg_i.set_bits};
  assign tag_o   = address_i >> tag_sh;

  always_comb begin
    for (int i = 0; i < SET_W; i++) begin
      set_o[i] = shifted[i] & (4'(i) < cfg_i.set_bits);
    end
  end

endmodule

/* rtl/core/salf_ram.sv */
// Single-port-write, single-port-read synchronous RAM holding one cache set per row.
// No dependencies.
module salf_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/core/salf_lookup.sv */
// Tag compare, victim choice and age-rank update for one cache set row.
// Depends on salf_pkg.
module salf_lookup #(
  parameter int ADDR_BITS = 48,
  parameter int MAX_WAYS  = 8,
  parameter int ROW_W     = 8
) (
  input  salf_pkg::cfg_t     cfg_i,
  input  logic [ROW_W-1:0]   row_i,
  input  logic [ADDR_BITS-1:0] tag_i,
  output salf_pkg::lk_res_t  res_o,
  output logic [ROW_W-1:0]   row_o
);
  import salf_pkg::*;

  localparam int AGE_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int WAY_W = AGE_W;
  localparam int CNT_W = $clog2(MAX_WAYS + 1);
  localparam int TAG_BASE = MAX_WAYS;
  localparam int AGE_BASE = MAX_WAYS * (1 + ADDR_BITS);

  logic [MAX_WAYS-1:0]  valid;
  logic [ADDR_BITS-1:0] tags [MAX_WAYS];
  logic [AGE_W-1:0]     ages [MAX_WAYS];
  logic [MAX_WAYS-1:0]  valid_n;
  logic [ADDR_BITS-1:0] tags_n [MAX_WAYS];
  logic [AGE_W-1:0]     ages_n [MAX_WAYS];
  logic [4:0]           ways_eff;
  logic                 found;
  logic                 hit;
  logic [WAY_W-1:0]     way_s;
  logic [WAY_W-1:0]     vic;
  logic [AGE_W-1:0]     best;
  logic [WAY_W-1:0]     way;
  logic [CNT_W-1:0]     cnt;
  logic                 upd;

  always_comb begin
    for (int w = 0; w < MAX_WAYS; w++) begin
      valid[w] = row_i[w];
      tags[w]  = row_i[TAG_BASE + w*ADDR_BITS +: ADDR_BITS];
      ages[w]  = row_i[AGE_BASE + w*AGE_W +: AGE_W];
    end
  end

  always_comb begin
    if (cfg_i.ways == 4'd0) begin
      ways_eff = 5'd1;
    end else if ({1'b0, cfg_i.ways} > 5'(MAX_WAYS)) begin
      ways_eff = 5'(MAX_WAYS);
    end else begin
      ways_eff = {1'b0, cfg_i.ways};
    end
  end

  always_comb begin
    found = 1'b0;
    hit   = 1'b0;
    way_s = '0;
    for (int w = 0; w < MAX_WAYS; w++) begin
      if (!found && (5'(w) < ways_eff)) begin
        if (!valid[w]) begin
          found = 1'b1;
          way_s = WAY_W'(w);
        end else if (tags[w] == tag_i) begin
          found = 1'b1;
          hit   = 1'b1;
          way_s = WAY_W'(w);
        end
      end
    end
  end

  always_comb begin
    best = ages[0];
    vic  = '0;
    for (int w = 1; w < MAX_WAYS; w++) begin
      if ((5'(w) < ways_eff) && (ages[w] < best)) begin
        best = ages[w];
        vic  = WAY_W'(w);
      end
    end
  end

  always_comb begin
    cnt = '0;
    for (int w = 0; w < MAX_WAYS; w++) begin
      cnt = cnt + CNT_W'(valid[w]);
    end
  end

  assign way = found ? way_s : vic;
  assign upd = !hit || (cfg_i.policy == POLICY_LRU);

  always_comb begin
    for (int v = 0; v < MAX_WAYS; v++) begin
      valid_n[v] = valid[v];
      tags_n[v]  = tags[v];
      ages_n[v]  = ages[v];
      if (upd) begin
        if (WAY_W'(v) == way) begin
          valid_n[v] = 1'b1;
          ages_n[v]  = valid[way] ? AGE_W'(cnt - CNT_W'(1)) : AGE_W'(cnt);
        end else if (valid[way] && valid[v] && (ages[v] > ages[way])) begin
          ages_n[v] = ages[v] - AGE_W'(1);
        end
      end
      if (!hit && (WAY_W'(v) == way)) begin
        tags_n[v] = tag_i;
      end
    end
  end

  always_comb begin
    row_o = '0;
    for (int w = 0; w < MAX_WAYS; w++) begin
      row_o[w]                                   = valid_n[w];
      row_o[TAG_BASE + w*ADDR_BITS +: ADDR_BITS] = tags_n[w];
      row_o[AGE_BASE + w*AGE_W +: AGE_W]         = ages_n[w];
    end
  end

  assign res_o.hit = hit;
  assign res_o.way = WAY_FLD_W'(way);

endmodule

/* tb/sv/tb_top.sv */
// Testbench for set_assoc_cache_lru_fifo: directed and random cache accesses under several
// geometries and both replacement policies, each result beat checked against an in-bench cache.
// Depends on salf_pkg and the RTL of the block; needs no files or arguments.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import salf_pkg::*;

  localparam int CLK_PERIOD   = 10;
  localparam int ADDR_W       = 48;
  localparam int NUM_WAYS     = 8;
  localparam int LINES        = CACHE_SETS * NUM_WAYS;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 8;
  localparam int PHASE_BEATS  = 135;

  typedef struct packed {
    logic        hit;
    logic [2:0]  way;
    logic        mem_read;
    logic        mem_write;
    logic [31:0] hits;
    logic [31:0] misses;
    logic [31:0] writes;
  } access_res_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_valid;
  logic                  in_ready;
  logic [ADDR_W-1:0]     in_address;
  logic                  in_is_write;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic                  out_hit;
  logic [2:0]            out_way_used;
  logic                  out_mem_read;
  logic                  out_mem_write;
  logic [31:0]           out_hit_total;
  logic [31:0]           out_miss_total;
  logic [31:0]           out_write_total;

  // cache image
  bit          line_vld  [LINES];
  bit [47:0]   line_tg   [LINES];
  bit [2:0]    line_rank [LINES];
  cfg_t        cache_cfg;
  bit [31:0]   hit_cnt;
  bit [31:0]   miss_cnt;
  bit [31:0]   write_cnt;

  access_res_t   pending_q[$];
  int unsigned   mismatches = 0;
  int unsigned   beats_seen = 0;
  int unsigned   cycle_cnt  = 0;
  int unsigned   tx_idle_pct = 7;
  int unsigned   rx_idle_pct = 47;
  int unsigned   rx_hold = 0;
  logic [47:0]   last_addr = '0;

  set_assoc_cache_lru_fifo #(
    .ADDR_BITS(ADDR_W),
    .MAX_WAYS (NUM_WAYS)
  ) u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_address     (in_address),
    .in_is_write    (in_is_write),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_hit        (out_hit),
    .out_way_used   (out_way_used),
    .out_mem_read   (out_mem_read),
    .out_mem_write  (out_mem_write),
    .out_hit_total  (out_hit_total),
    .out_miss_total (out_miss_total),
    .out_write_total(out_write_total)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  function automatic void clear_cache_image();
    foreach (line_vld[i]) begin
      line_vld[i]  = 1'b0;
      line_tg[i]   = '0;
      line_rank[i] = '0;
    end
    cache_cfg = '{policy: POLICY_LRU, ways: 4'd1, set_bits: 4'd0, offset_bits: 4'd0};
    hit_cnt   = '0;
    miss_cnt  = '0;
    write_cnt = '0;
  endfunction

  function automatic bit [31:0] sat_next(bit [31:0] v);
    return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

  // make way w the newest line of its set; ranks cover every valid line of the set
  function automatic void promote_line(int base, int w);
    int      cnt;
    bit [2:0] old;
    cnt = 0;
    for (int v = 0; v < NUM_WAYS; v++)
      if (line_vld[base + v]) cnt++;
    if (line_vld[base + w]) begin
      old = line_rank[base + w];
      for (int v = 0; v < NUM_WAYS; v++)
        if (v != w && line_vld[base + v] && line_rank[base + v] > old)
          line_rank[base + v] = line_rank[base + v] - 3'd1;
      line_rank[base + w] = 3'(cnt - 1);
    end else begin
      line_vld[base + w]  = 1'b1;
      line_rank[base + w] = 3'(cnt);
    end
  endfunction

  function automatic access_res_t predict_access(logic [47:0] addr, logic wr);
    access_res_t r;
    int          nw;
    int          ob;
    int          sb;
    int          base;
    bit [63:0]   a64;
    bit [63:0]   set_idx;
    bit [63:0]   tg;
    bit          found;
    bit [2:0]    oldest;
    nw = (cache_cfg.ways == 4'd0) ? 1 :
         ((int'(cache_cfg.ways) > NUM_WAYS) ? NUM_WAYS : int'(cache_cfg.ways));
    ob = int'(cache_cfg.offset_bits);
    sb = int'(cache_cfg.set_bits);
    a64 = 64'(addr);
    set_idx = (a64 >> ob) & ((64'd1 << sb) - 64'd1);
    tg = a64 >> (ob + sb);
    base = int'(set_idx[7:0]) * NUM_WAYS;
    r = '0;
    found = 1'b0;
    for (int v = 0; v < nw && !found; v++) begin
      if (!line_vld[base + v]) begin
        r.way = 3'(v);
        found = 1'b1;
      end else if (line_tg[base + v] == tg[47:0]) begin
        r.way = 3'(v);
        r.hit = 1'b1;
        found = 1'b1;
      end
    end
    if (r.hit) begin
      hit_cnt = sat_next(hit_cnt);
      if (cache_cfg.policy == POLICY_LRU) promote_line(base, int'(r.way));
    end else begin
      if (!found) begin
        oldest = line_rank[base];
        r.way = 3'd0;
        for (int v = 1; v < nw; v++)
          if (line_rank[base + v] < oldest) begin
            oldest = line_rank[base + v];
            r.way = 3'(v);
          end
      end
      miss_cnt = sat_next(miss_cnt);
      promote_line(base, int'(r.way));
      line_tg[base + int'(r.way)] = tg[47:0];
    end
    if (wr) write_cnt = sat_next(write_cnt);
    r.mem_read  = ~r.hit;
    r.mem_write = wr;
    r.hits      = hit_cnt;
    r.misses    = miss_cnt;
    r.writes    = write_cnt;
    return r;
  endfunction

  function automatic logic [47:0] make_addr(int unsigned tg, int unsigned set_n,
                                            int unsigned off);
    int        ob;
    int        sb;
    bit [63:0] a;
    ob = int'(cache_cfg.offset_bits);
    sb = int'(cache_cfg.set_bits);
    a = (64'(tg) << (ob + sb)) | ((64'(set_n) & ((64'd1 << sb) - 64'd1)) << ob) |
        (64'(off) & ((64'd1 << ob) - 64'd1));
    return a[47:0];
  endfunction

  function automatic logic [47:0] pick_address();
    int unsigned roll;
    int unsigned nw;
    bit [63:0]   a;
    roll = $urandom_range(0, 99);
    nw = (cache_cfg.ways == 4'd0) ? 1 : int'(cache_cfg.ways);
    if (roll < 10) begin
      a = {$urandom(), $urandom()};
      return a[47:0];
    end
    if (roll < 18) return last_addr;
    return make_addr($urandom_range(0, nw + 2), $urandom_range(0, 3), $urandom());
  endfunction

  // one access beat; entered and left at a falling edge
  task automatic issue_access(logic [47:0] addr, logic wr);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid    = 1'b1;
    in_address  = addr;
    in_is_write = wr;
    do @(posedge clk); while (!in_ready);
    pending_q.push_back(predict_access(addr, wr));
    last_addr = addr;
    @(negedge clk);
  endtask

  task automatic quiesce();
    in_valid = 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    case (idx)
      CFG_POLICY: cache_cfg.policy      = data[0];
      CFG_WAYS:   cache_cfg.ways        = data;
      CFG_SETB:   cache_cfg.set_bits    = data;
      CFG_OFFB:   cache_cfg.offset_bits = data;
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic set_geometry(cfg_t g);
    quiesce();
    set_reg(CFG_POLICY, CFG_DATA_W'(g.policy));
    set_reg(CFG_WAYS, g.ways);
    set_reg(CFG_SETB, g.set_bits);
    set_reg(CFG_OFFB, g.offset_bits);
  endtask

  task automatic test_reset_state();
    issue_access(48'h0, 1'b0);
    issue_access(48'h0, 1'b1);
    issue_access(48'hFFFF_FFFF_FFFF, 1'b1);
    issue_access(48'hFFFF_FFFF_FFFF, 1'b0);
    issue_access(48'h8000_0000_0001, 1'b0);
  endtask

  task automatic test_lru_order();
    set_geometry('{POLICY_LRU, 4'd4, 4'd2, 4'd4});
    for (int t = 1; t <= 4; t++) issue_access(make_addr(t, 1, t), 1'b0);
    issue_access(make_addr(1, 1, 0), 1'b1);
    issue_access(make_addr(5, 1, 0), 1'b0);
    issue_access(make_addr(2, 1, 0), 1'b1);
  endtask

  task automatic test_fifo_order();
    set_geometry('{POLICY_FIFO, 4'd4, 4'd2, 4'd4});
    for (int t = 1; t <= 4; t++) issue_access(make_addr(t, 2, 15), 1'b1);
    issue_access(make_addr(1, 2, 0), 1'b0);
    issue_access(make_addr(5, 2, 0), 1'b0);
    issue_access(make_addr(1, 2, 0), 1'b1);
  endtask

  task automatic test_geometry_corners();
    // zero ways acts as one; a wide set index wraps onto the set array
    set_geometry('{POLICY_LRU, 4'd0, 4'd12, 4'd15});
    issue_access(make_addr(3, 32'h101, 0), 1'b0);
    issue_access(make_addr(3, 32'h101, 5), 1'b1);
    set_geometry('{POLICY_LRU, 4'd15, 4'd8, 4'd0});
    issue_access(make_addr(9, 0, 0), 1'b0);
    // shrink the ways under a full set: victim ranks still count the hidden lines
    set_geometry('{POLICY_LRU, 4'd2, 4'd2, 4'd4});
    issue_access(make_addr(7, 1, 0), 1'b0);
  endtask

  task automatic test_backpressure();
    set_geometry('{POLICY_LRU, 4'd4, 4'd2, 4'd0});
    rx_hold = 80;
    repeat (40) issue_access(pick_address(), 1'($urandom_range(0, 1)));
    quiesce();
  endtask

  task automatic test_random_traffic();
    cfg_t g;
    for (int p = 0; p < 10; p++) begin
      case (p)
        0: g = '{POLICY_LRU, 4'd8, 4'd8, 4'd12};
        1: g = '{POLICY_FIFO, 4'd1, 4'd0, 4'd0};
        2: g = '{POLICY_LRU, 4'd15, 4'd15, 4'd15};
        3: g = '{POLICY_FIFO, 4'd8, 4'd1, 4'd0};
        default: g = '{1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)),
                       4'($urandom_range(0, 15)), 4'($urandom_range(0, 15))};
      endcase
      if (p < 3) begin
        tx_idle_pct = 7;
        rx_idle_pct = 47;
      end else if (p < 6) begin
        tx_idle_pct = 47;
        rx_idle_pct = 7;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      set_geometry(g);
      repeat (PHASE_BEATS) issue_access(pick_address(), 1'($urandom_range(0, 1)));
    end
  endtask

  always @(negedge clk) begin
    if (rx_hold > 0) begin
      out_ready = 1'b0;
      rx_hold   = rx_hold - 1;
    end else begin
      out_ready = ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  task automatic note_mismatch(string what, longint unsigned exp_v, longint unsigned act_v);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch beat %0d %s: expected %0h, got %0h", beats_seen, what, exp_v, act_v);
  endtask

  always @(posedge clk) begin
    access_res_t e;
    if (rst_n && out_valid && out_ready) begin
      if (pending_q.size() == 0) begin
        note_mismatch("unexpected beat", 64'd0, 64'd1);
      end else begin
        e = pending_q.pop_front();
        if (out_hit !== e.hit) note_mismatch("hit", 64'(e.hit), 64'(out_hit));
        if (out_way_used !== e.way)
          note_mismatch("way_used", 64'(e.way), 64'(out_way_used));
        if (out_mem_read !== e.mem_read)
          note_mismatch("mem_read", 64'(e.mem_read), 64'(out_mem_read));
        if (out_mem_write !== e.mem_write)
          note_mismatch("mem_write", 64'(e.mem_write), 64'(out_mem_write));
        if (out_hit_total !== e.hits)
          note_mismatch("hit_total", 64'(e.hits), 64'(out_hit_total));
        if (out_miss_total !== e.misses)
          note_mismatch("miss_total", 64'(e.misses), 64'(out_miss_total));
        if (out_write_total !== e.writes)
          note_mismatch("write_total", 64'(e.writes), 64'(out_write_total));
      end
      beats_seen++;
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    rst_n       = 1'b0;
    cfg_we      = 1'b0;
    cfg_index   = CFG_POLICY;
    cfg_data    = '0;
    in_valid    = 1'b0;
    in_address  = '0;
    in_is_write = 1'b0;
    clear_cache_image();
    repeat (11) @(negedge clk);
    rst_n = 1'b1;

    test_reset_state();
    test_lru_order();
    test_fifo_order();
    test_geometry_corners();
    test_backpressure();
    test_random_traffic();
    quiesce();

    if (mismatches == 0 && pending_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/core/salf_pkg.sv
rtl/core/salf_split.sv
rtl/core/salf_ram.sv
rtl/core/salf_lookup.sv
rtl/core/set_assoc_cache_lru_fifo.sv
tb/sv/tb_top.sv
